// File: design/fpsp_pkg.sv
// Shared constants for the framed packet sync parser.
`default_nettype none
package fpsp_pkg;

  localparam int LEN_BITS = 16;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h55;
  localparam logic [15:0] OVERHEAD = 16'd7;
  localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd263;
  localparam logic [15:0] LEN_CAP = 16'((32'd1 << LEN_BITS) - 32'd1);

  typedef logic [2:0] event_t;
  localparam event_t EV_NONE    = 3'd0;
  localparam event_t EV_BYTE    = 3'd1;
  localparam event_t EV_DONE    = 3'd2;
  localparam event_t EV_BADLEN  = 3'd3;
  localparam event_t EV_BADSUM  = 3'd4;
  localparam event_t EV_BADTAIL = 3'd5;

  // Payload length limit for a given buffer size; zero rejects every length.
  function automatic logic [15:0] len_limit(input logic [15:0] max_len);
    logic [15:0] lim;
    begin
      if (max_len < OVERHEAD) begin
        lim = '0;
      end else begin
        lim = max_len - OVERHEAD;
      end
      if (lim > LEN_CAP) begin
        lim = LEN_CAP;
      end
      return lim;
    end
  endfunction

endpackage
`default_nettype wire

// File: design/framed_packet_sync_parser.sv
// Top level of the framed packet sync parser.
// Hunts a byte stream for frames AA 55, 16-bit big-endian length, payload,
// XOR checksum, 55 AA. Each accepted byte yields exactly one result next cycle:
// payload bytes with their index, a frame-complete event with the total
// frame length, bad length / checksum / tail events, or "none". One byte is
// taken per cycle; the parse state and the result register update in the same
// cycle, so the only bound on rate is the result register: a new byte is taken
// whenever the held result is being transferred or none is held. Writing cfg
// sets the receive buffer size; the payload limit is that size minus seven.
`default_nettype none
module framed_packet_sync_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_rx_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fpsp_pkg::event_t         out_event_res,
  output logic [7:0]               out_payload_byte,
  output logic [15:0]              out_payload_index,
  output logic [15:0]              out_frame_length
);
  import fpsp_pkg::*;

  localparam logic [2:0] PH_HUNT1 = 3'd0;
  localparam logic [2:0] PH_HUNT2 = 3'd1;
  localparam logic [2:0] PH_LENH  = 3'd2;
  localparam logic [2:0] PH_LENL  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;
  localparam logic [2:0] PH_TAIL1 = 3'd6;
  localparam logic [2:0] PH_TAIL2 = 3'd7;

  logic [15:0] limit_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  xor_r, xor_nxt;

  logic        out_valid_r;
  event_t      ev_r, ev_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [15:0] pidx_r, pidx_nxt;
  logic [15:0] flen_r, flen_nxt;

  logic        in_xfer;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign len_full  = {len_r[15:8], in_rx_byte};
  assign count_inc = count_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    xor_nxt   = xor_r;
    ev_nxt    = EV_NONE;
    pbyte_nxt = '0;
    pidx_nxt  = '0;
    flen_nxt  = '0;
    case (phase_r)
      PH_HUNT1: begin
        if (in_rx_byte == SYNC_A) phase_nxt = PH_HUNT2;
      end
      PH_HUNT2: begin
        // a repeated AA keeps waiting for 55
        if (in_rx_byte == SYNC_B) begin
          phase_nxt = PH_LENH;
        end else if (in_rx_byte != SYNC_A) begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_LENH: begin
        len_nxt   = {in_rx_byte, 8'h00};
        phase_nxt = PH_LENL;
      end
      PH_LENL: begin
        if (len_full == '0 || len_full > limit_r) begin
          ev_nxt    = EV_BADLEN;
          len_nxt   = '0;
          phase_nxt = PH_HUNT1;
        end else begin
          len_nxt   = len_full;
          count_nxt = '0;
          xor_nxt   = '0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        ev_nxt    = EV_BYTE;
        pbyte_nxt = in_rx_byte;
        pidx_nxt  = count_r;
        xor_nxt   = xor_r ^ in_rx_byte;
        count_nxt = count_inc;
        if (count_inc >= len_r) phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        if (xor_r == in_rx_byte) begin
          phase_nxt = PH_TAIL1;
        end else begin
          ev_nxt    = EV_BADSUM;
          len_nxt   = '0;
          phase_nxt = PH_HUNT1;
        end
      end
      PH_TAIL1: begin
        if (in_rx_byte == SYNC_B) begin
          phase_nxt = PH_TAIL2;
        end else begin
          ev_nxt    = EV_BADTAIL;
          len_nxt   = '0;
          phase_nxt = PH_HUNT1;
        end
      end
      PH_TAIL2: begin
        if (in_rx_byte == SYNC_A) begin
          ev_nxt   = EV_DONE;
          flen_nxt = count_r + OVERHEAD;
        end else begin
          ev_nxt = EV_BADTAIL;
        end
        len_nxt   = '0;
        phase_nxt = PH_HUNT1;
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= len_limit(MAX_FRAME_LEN_RST);
      phase_r     <= PH_HUNT1;
      len_r       <= '0;
      count_r     <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= len_limit(cfg_wdata);
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        len_r       <= len_nxt;
        count_r     <= count_nxt;
        xor_r       <= xor_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_r    <= ev_nxt;
      pbyte_r <= pbyte_nxt;
      pidx_r  <= pidx_nxt;
      flen_r  <= flen_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_payload_byte  = pbyte_r;
  assign out_payload_index = pidx_r;
  assign out_frame_length  = flen_r;

  // a byte taken while hunting for the first sync byte never reports an event
  a_hunt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && phase_r == PH_HUNT1 |=> out_event_res == EV_NONE)
    else $error("event reported from hunt phase");

  // payload phase only runs with a nonzero length and the count below it
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> (len_r != '0 && count_r < len_r))
    else $error("payload phase with bad length or count");

  // frame length always covers at least one payload byte plus overhead
  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_DONE |-> out_frame_length > OVERHEAD)
    else $error("frame complete with short length");

  // non-byte events carry a zero payload byte and index
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_BYTE |->
      (out_payload_byte == '0 && out_payload_index == '0))
    else $error("stray payload fields");

endmodule
`default_nettype wire
